/* rtl/sfcs_pkg.sv */
// shared types, opcodes and helpers for the serial flash command sequencer
`default_nettype none

package sfcs_pkg;

    // field widths
    localparam int ADDR_W  = 24;
    localparam int COUNT_W = 16;
    localparam int BYTE_W  = 8;

    // flash geometry, both powers of two
    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;
    localparam int PAGE_LOG     = $clog2(PAGE_BYTES);
    localparam int SECTOR_LOG   = $clog2(SECTOR_BYTES);

    // most bus actions one word's list can hold, and the counter width for it
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // command codes
    typedef enum logic [3:0] {
        CMD_READ   = 4'd0,
        CMD_WRITE  = 4'd1,
        CMD_DATA   = 4'd2,
        CMD_SECTOR = 4'd3,
        CMD_CHIP   = 4'd4,
        CMD_ID     = 4'd5,
        CMD_STATUS = 4'd6,
        CMD_WSTAT  = 4'd7,
        CMD_SLEEP  = 4'd8,
        CMD_WAKE   = 4'd9
    } cmd_t;

    // bus action codes
    typedef enum logic [1:0] {
        ACT_REFUSE = 2'd0,
        ACT_XFER   = 2'd1,
        ACT_POLL   = 2'd2
    } action_t;

    // open frame
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } mode_t;

    // flash opcodes
    localparam logic [7:0] OP_WREN   = 8'h06;
    localparam logic [7:0] OP_RDSR   = 8'h05;
    localparam logic [7:0] OP_WRSR   = 8'h01;
    localparam logic [7:0] OP_READ   = 8'h03;
    localparam logic [7:0] OP_PP     = 8'h02;
    localparam logic [7:0] OP_SE     = 8'h20;
    localparam logic [7:0] OP_CE     = 8'hC7;
    localparam logic [7:0] OP_RDID   = 8'h90;
    localparam logic [7:0] OP_PD     = 8'hB9;
    localparam logic [7:0] OP_RPD    = 8'hAB;
    localparam logic [7:0] DUMMY     = 8'hFF;

    // input word
    typedef struct packed {
        logic [3:0]         cmd;
        logic [ADDR_W-1:0]  address;
        logic [COUNT_W-1:0] byte_count;
        logic [BYTE_W-1:0]  data_byte;
    } cmd_word_t;

    // result word
    typedef struct packed {
        logic [1:0]        action;
        logic [BYTE_W-1:0] mosi_byte;
        logic              cs_begin;
        logic              cs_end;
        logic              capture;
        logic              last;
    } rsp_word_t;

    // all results of one input word, entry 0 goes out first
    typedef struct packed {
        logic [CNT_W-1:0]                  count;
        rsp_word_t [MAX_RESULTS-1:0]       entry;
    } burst_t;

    // one byte transfer
    function automatic rsp_word_t xfer(logic [7:0] b, logic cs_b, logic cs_e, logic cap);
        rsp_word_t w;
        w.action    = ACT_XFER;
        w.mosi_byte = b;
        w.cs_begin  = cs_b;
        w.cs_end    = cs_e;
        w.capture   = cap;
        w.last      = 1'b0;
        return w;
    endfunction

    // wait until the busy bit clears
    function automatic rsp_word_t poll_busy();
        rsp_word_t w;
        w.action    = ACT_POLL;
        w.mosi_byte = OP_RDSR;
        w.cs_begin  = 1'b0;
        w.cs_end    = 1'b0;
        w.capture   = 1'b0;
        w.last      = 1'b0;
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/sfcs_decode.sv */
// command decode: frame state and the list of bus actions for one word
`default_nettype none

module sfcs_decode
    import sfcs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      accept,
    input  wire cmd_word_t cmd_word,
    output burst_t         burst
);

    mode_t               mode_reg, mode_next;
    logic [ADDR_W-1:0]   next_address_reg, next_address_next;
    logic [COUNT_W-1:0]  bytes_left_reg, bytes_left_next;

    logic [COUNT_W-1:0]  left_dec;
    logic [ADDR_W-1:0]   addr_inc;
    logic [ADDR_W-1:0]   sector_addr;
    logic                page_end;
    logic                rd_ok;
    logic                wr_ok;
    burst_t              list;

    // shared arithmetic
    assign left_dec    = bytes_left_reg - COUNT_W'(1);
    assign addr_inc    = next_address_reg + ADDR_W'(1);
    assign page_end    = (addr_inc[PAGE_LOG-1:0] == '0);
    assign sector_addr = cmd_word.address << SECTOR_LOG;
    assign rd_ok       = (mode_reg == MODE_READ)  && (bytes_left_reg != '0);
    assign wr_ok       = (mode_reg == MODE_WRITE) && (bytes_left_reg != '0);

    // next frame state
    always_comb
    begin
        mode_next         = mode_reg;
        next_address_next = next_address_reg;
        bytes_left_next   = bytes_left_reg;
        if (cmd_word.cmd == CMD_DATA)
        begin
            if (rd_ok)
            begin
                bytes_left_next = left_dec;
                if (left_dec == '0)
                    mode_next = MODE_IDLE;
            end
            else if (wr_ok)
            begin
                bytes_left_next   = left_dec;
                next_address_next = addr_inc;
                if (left_dec == '0)
                    mode_next = MODE_IDLE;
            end
        end
        else if (mode_reg == MODE_IDLE && cmd_word.byte_count != '0)
        begin
            if (cmd_word.cmd == CMD_READ)
            begin
                mode_next       = MODE_READ;
                bytes_left_next = cmd_word.byte_count;
            end
            else if (cmd_word.cmd == CMD_WRITE)
            begin
                mode_next         = MODE_WRITE;
                bytes_left_next   = cmd_word.byte_count;
                next_address_next = cmd_word.address;
            end
        end
    end

    // bus action list
    always_comb
    begin
        list = '0;
        if (cmd_word.cmd == CMD_DATA)
        begin
            if (rd_ok)
            begin
                list.entry[0] = xfer(DUMMY, 1'b0, left_dec == '0, 1'b1);
                list.count    = CNT_W'(1);
            end
            else if (wr_ok)
            begin
                if (left_dec == '0 || page_end)
                begin
                    list.entry[0] = xfer(cmd_word.data_byte, 1'b0, 1'b1, 1'b0);
                    list.entry[1] = poll_busy();
                    list.count    = CNT_W'(2);
                    if (left_dec != '0)
                    begin
                        // next page header
                        list.entry[2] = xfer(OP_WREN, 1'b1, 1'b1, 1'b0);
                        list.entry[3] = xfer(OP_PP, 1'b1, 1'b0, 1'b0);
                        list.entry[4] = xfer(addr_inc[23:16], 1'b0, 1'b0, 1'b0);
                        list.entry[5] = xfer(addr_inc[15:8], 1'b0, 1'b0, 1'b0);
                        list.entry[6] = xfer(addr_inc[7:0], 1'b0, 1'b0, 1'b0);
                        list.count    = CNT_W'(7);
                    end
                end
                else
                begin
                    list.entry[0] = xfer(cmd_word.data_byte, 1'b0, 1'b0, 1'b0);
                    list.count    = CNT_W'(1);
                end
            end
        end
        else if (mode_reg == MODE_IDLE)
        begin
            case (cmd_word.cmd)
                CMD_READ:
                begin
                    if (cmd_word.byte_count != '0)
                    begin
                        list.entry[0] = xfer(OP_READ, 1'b1, 1'b0, 1'b0);
                        list.entry[1] = xfer(cmd_word.address[23:16], 1'b0, 1'b0, 1'b0);
                        list.entry[2] = xfer(cmd_word.address[15:8], 1'b0, 1'b0, 1'b0);
                        list.entry[3] = xfer(cmd_word.address[7:0], 1'b0, 1'b0, 1'b0);
                        list.count    = CNT_W'(4);
                    end
                end
                CMD_WRITE:
                begin
                    if (cmd_word.byte_count != '0)
                    begin
                        list.entry[0] = xfer(OP_WREN, 1'b1, 1'b1, 1'b0);
                        list.entry[1] = xfer(OP_PP, 1'b1, 1'b0, 1'b0);
                        list.entry[2] = xfer(cmd_word.address[23:16], 1'b0, 1'b0, 1'b0);
                        list.entry[3] = xfer(cmd_word.address[15:8], 1'b0, 1'b0, 1'b0);
                        list.entry[4] = xfer(cmd_word.address[7:0], 1'b0, 1'b0, 1'b0);
                        list.count    = CNT_W'(5);
                    end
                end
                CMD_SECTOR:
                begin
                    list.entry[0] = xfer(OP_WREN, 1'b1, 1'b1, 1'b0);
                    list.entry[1] = poll_busy();
                    list.entry[2] = xfer(OP_SE, 1'b1, 1'b0, 1'b0);
                    list.entry[3] = xfer(sector_addr[23:16], 1'b0, 1'b0, 1'b0);
                    list.entry[4] = xfer(sector_addr[15:8], 1'b0, 1'b0, 1'b0);
                    list.entry[5] = xfer(sector_addr[7:0], 1'b0, 1'b1, 1'b0);
                    list.entry[6] = poll_busy();
                    list.count    = CNT_W'(7);
                end
                CMD_CHIP:
                begin
                    list.entry[0] = xfer(OP_WREN, 1'b1, 1'b1, 1'b0);
                    list.entry[1] = poll_busy();
                    list.entry[2] = xfer(OP_CE, 1'b1, 1'b1, 1'b0);
                    list.entry[3] = poll_busy();
                    list.count    = CNT_W'(4);
                end
                CMD_ID:
                begin
                    list.entry[0] = xfer(OP_RDID, 1'b1, 1'b0, 1'b0);
                    list.entry[1] = xfer(8'h00, 1'b0, 1'b0, 1'b0);
                    list.entry[2] = xfer(8'h00, 1'b0, 1'b0, 1'b0);
                    list.entry[3] = xfer(8'h00, 1'b0, 1'b0, 1'b0);
                    list.entry[4] = xfer(DUMMY, 1'b0, 1'b0, 1'b1);
                    list.entry[5] = xfer(DUMMY, 1'b0, 1'b1, 1'b1);
                    list.count    = CNT_W'(6);
                end
                CMD_STATUS:
                begin
                    list.entry[0] = xfer(OP_RDSR, 1'b1, 1'b0, 1'b0);
                    list.entry[1] = xfer(DUMMY, 1'b0, 1'b1, 1'b1);
                    list.count    = CNT_W'(2);
                end
                CMD_WSTAT:
                begin
                    list.entry[0] = xfer(OP_WRSR, 1'b1, 1'b0, 1'b0);
                    list.entry[1] = xfer(cmd_word.data_byte, 1'b0, 1'b1, 1'b0);
                    list.count    = CNT_W'(2);
                end
                CMD_SLEEP:
                begin
                    list.entry[0] = xfer(OP_PD, 1'b1, 1'b1, 1'b0);
                    list.count    = CNT_W'(1);
                end
                CMD_WAKE:
                begin
                    list.entry[0] = xfer(OP_RPD, 1'b1, 1'b1, 1'b0);
                    list.count    = CNT_W'(1);
                end
                default:
                begin
                    list = '0;
                end
            endcase
        end
    end

    // refusal when nothing was produced, then mark the final entry
    always_comb
    begin
        burst = list;
        if (list.count == '0)
        begin
            burst       = '0;
            burst.count = CNT_W'(1);
        end
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            burst.entry[i].last = ((CNT_W'(i) + CNT_W'(1)) == burst.count);
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            next_address_reg <= '0;
            bytes_left_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg         <= mode_next;
            next_address_reg <= next_address_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/sfcs_emit.sv */
// action queue: holds one word's bus actions and hands them out one per cycle unless the output is stalled
`default_nettype none

module sfcs_emit
    import sfcs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   load,
    input  wire burst_t burst,
    output logic        full,
    output logic        rsp_valid,
    input  wire logic   rsp_stall,
    output rsp_word_t   rsp_word
);

    rsp_word_t [MAX_RESULTS-1:0] entry_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        rsp_valid_reg;
    rsp_word_t                   rsp_word_reg;
    logic                        out_free;
    logic                        pop;

    // output slot frees when empty or taken this cycle
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign pop      = (cnt_reg != '0) && out_free;

    // a new word may enter once the final action is leaving
    assign full = (cnt_reg > CNT_W'(1)) || ((cnt_reg == CNT_W'(1)) && !out_free);

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // queue count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (load)
            cnt_reg <= burst.count;
        else if (pop)
            cnt_reg <= cnt_reg - CNT_W'(1);
    end

    // queue entries, shifted toward entry 0
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= burst.entry;
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                entry_reg[i] <= entry_reg[i + 1];
            end
            entry_reg[MAX_RESULTS-1] <= '0;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (out_free)
            rsp_valid_reg <= (cnt_reg != '0);
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (pop)
            rsp_word_reg <= entry_reg[0];
    end

`ifndef SYNTHESIS
    a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (burst.count != '0) && (burst.count < CNT_W'(MAX_RESULTS)))
        else $error("action list loaded with bad count");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && pop))
        else $error("action list overwritten before drained");

    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (cnt_reg == CNT_W'(1))) |-> entry_reg[0].last)
        else $error("final action of a word lacks last mark");

    a_no_early_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (cnt_reg > CNT_W'(1))) |-> !entry_reg[0].last)
        else $error("last mark before the final action");

    a_out_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> rsp_valid_reg)
        else $error("popped action not presented");
`endif

endmodule

`default_nettype wire

/* rtl/spi_flash_command_sequencer.sv */
// top level of the serial NOR flash command sequencer
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd_word) takes one command or data
//   word at a rising edge with cmd_valid high and cmd_stall low.
//   rsp channel (rsp_valid / rsp_stall / rsp_word) gives the bus actions the
//   word causes, in bus order, one per cycle while rsp_stall is low; the
//   final one has last set. A word causes 1 to 7 actions; a data word that
//   causes one action can follow every cycle while rsp_stall is low.
//   The first action of a word reaches rsp_word through the action queue
//   and the output register. The next word is taken in the cycle the
//   previous word's final action moves into the output register, so the
//   queue and output overlap. rsp_stall holds the output register; the
//   queue then stops and cmd_stall rises once the queue cannot take
//   another word. Reset closes any open frame, clears the write address
//   and byte count and empties the queue and the output register.
`default_nettype none

module spi_flash_command_sequencer
    import sfcs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_word_t cmd_word,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_word_t      rsp_word
);

    logic   accept;
    logic   full;
    burst_t burst;

    assign cmd_stall = full;
    assign accept    = cmd_valid && !full;

    // decode and frame state
    sfcs_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .cmd_word (cmd_word),
        .burst    (burst)
    );

    // action queue and output register
    sfcs_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .burst     (burst),
        .full      (full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

`default_nettype wire

/* sim/tb.sv */
// testbench for the serial flash command sequencer: paced words in, bus actions checked in order
`timescale 1ns / 1ps

import sfcs_pkg::*;

// predicts the bus actions of every accepted word and checks the actions that come out
class action_board;
    rsp_word_t          pending_actions[$];
    rsp_word_t          word_actions[$];
    int                 mismatches;
    mode_t              frame_mode;
    logic [ADDR_W-1:0]  write_addr;
    logic [COUNT_W-1:0] bytes_left;

    function new();
        frame_mode = MODE_IDLE;
        write_addr = '0;
        bytes_left = '0;
        mismatches = 0;
    endfunction

    function void push_xfer(logic [7:0] b, logic cs_b, logic cs_e, logic cap);
        rsp_word_t r;
        r.action    = ACT_XFER;
        r.mosi_byte = b;
        r.cs_begin  = cs_b;
        r.cs_end    = cs_e;
        r.capture   = cap;
        r.last      = 1'b0;
        word_actions.push_back(r);
    endfunction

    function void push_poll();
        rsp_word_t r;
        r           = '0;
        r.action    = ACT_POLL;
        r.mosi_byte = OP_RDSR;
        word_actions.push_back(r);
    endfunction

    // three address bytes, high byte first
    function void push_addr(logic [ADDR_W-1:0] a, logic end_frame);
        push_xfer(a[23:16], 1'b0, 1'b0, 1'b0);
        push_xfer(a[15:8], 1'b0, 1'b0, 1'b0);
        push_xfer(a[7:0], 1'b0, end_frame, 1'b0);
    endfunction

    // write enable, page program and address of one page
    function void push_page_header(logic [ADDR_W-1:0] a);
        push_xfer(OP_WREN, 1'b1, 1'b1, 1'b0);
        push_xfer(OP_PP, 1'b1, 1'b0, 1'b0);
        push_addr(a, 1'b0);
    endfunction

    // work out the actions of one accepted word and queue them
    function void note_word(cmd_word_t w);
        rsp_word_t r;
        logic      refused;
        word_actions.delete();
        refused = 1'b0;
        if (w.cmd == CMD_DATA)
        begin
            if (frame_mode == MODE_READ && bytes_left != 0)
            begin
                bytes_left = bytes_left - 1'b1;
                push_xfer(DUMMY, 1'b0, bytes_left == 0, 1'b1);
                if (bytes_left == 0)
                    frame_mode = MODE_IDLE;
            end
            else if (frame_mode == MODE_WRITE && bytes_left != 0)
            begin
                bytes_left = bytes_left - 1'b1;
                write_addr = write_addr + 1'b1;
                // frame closes at the last byte or at a page boundary
                if (bytes_left == 0 || write_addr[PAGE_LOG-1:0] == 0)
                begin
                    push_xfer(w.data_byte, 1'b0, 1'b1, 1'b0);
                    push_poll();
                    if (bytes_left == 0)
                        frame_mode = MODE_IDLE;
                    else
                        push_page_header(write_addr);
                end
                else
                begin
                    push_xfer(w.data_byte, 1'b0, 1'b0, 1'b0);
                end
            end
            else
            begin
                refused = 1'b1;
            end
        end
        else if (frame_mode != MODE_IDLE)
        begin
            refused = 1'b1;
        end
        else
        begin
            case (w.cmd)
                CMD_READ:
                begin
                    if (w.byte_count == 0)
                    begin
                        refused = 1'b1;
                    end
                    else
                    begin
                        push_xfer(OP_READ, 1'b1, 1'b0, 1'b0);
                        push_addr(w.address, 1'b0);
                        frame_mode = MODE_READ;
                        bytes_left = w.byte_count;
                    end
                end
                CMD_WRITE:
                begin
                    if (w.byte_count == 0)
                    begin
                        refused = 1'b1;
                    end
                    else
                    begin
                        push_page_header(w.address);
                        frame_mode = MODE_WRITE;
                        bytes_left = w.byte_count;
                        write_addr = w.address;
                    end
                end
                CMD_SECTOR:
                begin
                    push_xfer(OP_WREN, 1'b1, 1'b1, 1'b0);
                    push_poll();
                    push_xfer(OP_SE, 1'b1, 1'b0, 1'b0);
                    push_addr(w.address << SECTOR_LOG, 1'b1);
                    push_poll();
                end
                CMD_CHIP:
                begin
                    push_xfer(OP_WREN, 1'b1, 1'b1, 1'b0);
                    push_poll();
                    push_xfer(OP_CE, 1'b1, 1'b1, 1'b0);
                    push_poll();
                end
                CMD_ID:
                begin
                    push_xfer(OP_RDID, 1'b1, 1'b0, 1'b0);
                    push_addr('0, 1'b0);
                    push_xfer(DUMMY, 1'b0, 1'b0, 1'b1);
                    push_xfer(DUMMY, 1'b0, 1'b1, 1'b1);
                end
                CMD_STATUS:
                begin
                    push_xfer(OP_RDSR, 1'b1, 1'b0, 1'b0);
                    push_xfer(DUMMY, 1'b0, 1'b1, 1'b1);
                end
                CMD_WSTAT:
                begin
                    push_xfer(OP_WRSR, 1'b1, 1'b0, 1'b0);
                    push_xfer(w.data_byte, 1'b0, 1'b1, 1'b0);
                end
                CMD_SLEEP: push_xfer(OP_PD, 1'b1, 1'b1, 1'b0);
                CMD_WAKE:  push_xfer(OP_RPD, 1'b1, 1'b1, 1'b0);
                default:   refused = 1'b1;
            endcase
        end
        // a refused word gives one empty action and leaves the state alone
        if (refused)
        begin
            word_actions.delete();
            r        = '0;
            r.action = ACT_REFUSE;
            word_actions.push_back(r);
        end
        word_actions[word_actions.size()-1].last = 1'b1;
        foreach (word_actions[i])
            pending_actions.push_back(word_actions[i]);
    endfunction

    // printable form of one action
    function string act_text(rsp_word_t r);
        return $sformatf("act=%0d byte=%02h b=%0b e=%0b cap=%0b last=%0b",
                         r.action, r.mosi_byte, r.cs_begin, r.cs_end, r.capture, r.last);
    endfunction

    // compare one accepted action with the oldest prediction
    function void check_action(rsp_word_t got);
        rsp_word_t exp;
        if (pending_actions.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected action, expected none, got %s",
                     $time, act_text(got));
            return;
        end
        exp = pending_actions.pop_front();
        if (got !== exp)
        begin
            mismatches++;
            $display("%0t: action mismatch, expected %s, got %s",
                     $time, act_text(exp), act_text(got));
        end
    endfunction
endclass

module tb;
    localparam int RANDOM_WORDS = 410;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 200000;

    // command codes with no meaning, refused by the block
    localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_word_t cmd_word  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp_word;

    action_board board;
    int          sent_words  = 0;
    int          burst_left  = 0;
    logic        steady      = 1'b0;
    logic        hold_req    = 1'b0;
    int          cycle_count = 0;

    spi_flash_command_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_action(rsp_word);
    end

    // receiver stall pattern, with a long hold-off on request
    initial
    begin : rsp_pacer
        int pace_mode;
        int pace_left;
        int hold_left;
        pace_mode = 0;
        pace_left = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                if (pace_left == 0)
                begin
                    pace_mode = $urandom_range(0, 3);
                    pace_left = $urandom_range(40, 200);
                end
                pace_left--;
                case (pace_mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    2:       rsp_stall <= ($urandom_range(0, 9) < 7);
                    default: rsp_stall <= (pace_left % 3 == 0);
                endcase
            end
        end
    end

    function automatic cmd_word_t make_word(logic [3:0] c, logic [ADDR_W-1:0] a,
                                            logic [COUNT_W-1:0] n, logic [7:0] d);
        cmd_word_t w;
        w.cmd        = c;
        w.address    = a;
        w.byte_count = n;
        w.data_byte  = d;
        return w;
    endfunction

    // word with random address, count and data
    function automatic cmd_word_t random_word(logic [3:0] c);
        return make_word(c, ADDR_W'($urandom), COUNT_W'($urandom), BYTE_W'($urandom));
    endfunction

    // offer one word from a falling edge until it is taken, return at a falling edge
    task automatic send_word(cmd_word_t w);
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        board.note_word(w);
        sent_words++;
        @(negedge clk);
    endtask

    // sender pacing: bursts of words with random gaps between them
    task automatic put_word(cmd_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        send_word(w);
        burst_left--;
    endtask

    // any command word except data, fields at random
    task automatic put_noise();
        logic [3:0] c;
        c = 4'($urandom_range(0, 15));
        while (c == CMD_DATA)
            c = 4'($urandom_range(0, 15));
        put_word(random_word(c));
    endtask

    // data words of an open frame, now and then a refused command in between
    task automatic put_frame_data(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                put_noise();
            put_word(random_word(CMD_DATA));
        end
    endtask

    task automatic run_directed();
        // data while idle, zero counts, unused codes
        put_word(make_word(CMD_DATA, '0, '0, 8'hFF));
        put_word(make_word(CMD_READ, 24'h123456, '0, '0));
        put_word(make_word(CMD_WRITE, 24'hFFFFFF, '0, 8'hFF));
        put_word(make_word(CMD_UNUSED_HI, 24'hFFFFFF, 16'hFFFF, 8'hFF));
        put_word(make_word(CMD_UNUSED_LO, '0, 16'd1, '0));
        // read at the top address, command refused while the frame is open
        put_word(make_word(CMD_READ, 24'hFFFFFF, 16'd2, '0));
        put_word(make_word(CMD_WAKE, '0, 16'hFFFF, '0));
        put_word(make_word(CMD_DATA, '0, '0, 8'h00));
        put_word(make_word(CMD_DATA, 24'hFFFFFF, 16'hFFFF, 8'hFF));
        // write that wraps the address and crosses a page end
        put_word(make_word(CMD_WRITE, 24'hFFFFFE, 16'd4, '0));
        put_word(make_word(CMD_CHIP, '0, '0, '0));
        put_word(make_word(CMD_DATA, '0, '0, 8'h00));
        put_word(make_word(CMD_DATA, '0, '0, 8'hFF));
        put_word(make_word(CMD_DATA, '0, '0, 8'hA5));
        put_word(make_word(CMD_DATA, '0, '0, 8'h5A));
        put_word(make_word(CMD_DATA, '0, '0, 8'h11));
        // sector index extremes and the single commands
        put_word(make_word(CMD_SECTOR, 24'hFFFFFF, '0, '0));
        put_word(make_word(CMD_SECTOR, '0, '0, '0));
        put_word(make_word(CMD_CHIP, '0, '0, '0));
        put_word(make_word(CMD_ID, 24'hFFFFFF, 16'hFFFF, 8'hFF));
        put_word(make_word(CMD_STATUS, '0, '0, '0));
        put_word(make_word(CMD_WSTAT, '0, '0, 8'hFF));
        put_word(make_word(CMD_WSTAT, '0, '0, 8'h00));
        put_word(make_word(CMD_SLEEP, '0, '0, '0));
        put_word(make_word(CMD_WAKE, '0, '0, '0));
    endtask

    // one random sequence: mostly complete frames and commands, some noise
    task automatic put_random_sequence();
        cmd_word_t w;
        int        pick;
        int        n;
        pick = $urandom_range(0, 99);
        w    = random_word(CMD_READ);
        if (pick < 30)
        begin
            n            = $urandom_range(1, 12);
            w.byte_count = COUNT_W'(n);
            put_word(w);
            put_frame_data(n);
        end
        else if (pick < 60)
        begin
            w.cmd = CMD_WRITE;
            n     = ($urandom_range(0, 39) == 0) ? $urandom_range(257, 300)
                                                 : $urandom_range(1, 20);
            // start close to a page end half of the time
            if ($urandom_range(0, 1) == 1)
                w.address[PAGE_LOG-1:0] = PAGE_LOG'(PAGE_BYTES - $urandom_range(1, 16));
            w.byte_count = COUNT_W'(n);
            put_word(w);
            put_frame_data(n);
        end
        else if (pick < 88)
        begin
            w.cmd = 4'($urandom_range(CMD_SECTOR, CMD_WAKE));
            put_word(w);
        end
        else if (pick < 93)
        begin
            w.cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            put_word(w);
        end
        else if (pick < 97)
        begin
            w.cmd        = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
            w.byte_count = '0;
            put_word(w);
        end
        else
        begin
            w.cmd = CMD_DATA;
            put_word(w);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        board = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        // back-to-back words while the receiver holds off for a long stretch
        steady   = 1'b1;
        hold_req = 1'b1;
        while (sent_words < 85)
            put_random_sequence();
        steady = 1'b0;
        while (sent_words < RANDOM_WORDS)
            put_random_sequence();
        cmd_valid <= 1'b0;
        while (board.pending_actions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

/* sim.f */
rtl/sfcs_pkg.sv
rtl/sfcs_decode.sv
rtl/sfcs_emit.sv
rtl/spi_flash_command_sequencer.sv
sim/tb.sv
